// ----- rtl/gpt_pkg.sv -----
// Shared types and register map constants for the general purpose timer.
package gpt_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned OFFSET_W = 8;
   localparam int unsigned KIND_W = 2;

   // request kinds; the fourth code is unused and does nothing
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

   // register byte offsets
   localparam logic [OFFSET_W-1:0] OFF_CR1  = 8'h00;
   localparam logic [OFFSET_W-1:0] OFF_DIER = 8'h0C;
   localparam logic [OFFSET_W-1:0] OFF_SR   = 8'h10;
   localparam logic [OFFSET_W-1:0] OFF_CNT  = 8'h24;
   localparam logic [OFFSET_W-1:0] OFF_PSC  = 8'h28;
   localparam logic [OFFSET_W-1:0] OFF_ARR  = 8'h2C;

   localparam logic [DATA_W-1:0] ARR_RESET = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [OFFSET_W-1:0] reg_offset;
      logic [DATA_W-1:0]   write_data;
   } gpt_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              write_error;
      logic              irq_pulse;
   } gpt_rsp_type;

endpackage

// ----- rtl/gpt_if.sv -----
// Valid/ready channel interfaces for timer requests and responses.
interface gpt_req_if import gpt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [OFFSET_W-1:0] reg_offset;
   logic [DATA_W-1:0]   write_data;

   modport source (output valid, output kind, output reg_offset, output write_data,
                   input ready);
   modport sink   (input valid, input kind, input reg_offset, input write_data,
                   output ready);
endinterface

interface gpt_rsp_if import gpt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              write_error;
   logic              irq_pulse;

   modport source (output valid, output read_data, output write_error, output irq_pulse,
                   input ready);
   modport sink   (input valid, input read_data, input write_error, input irq_pulse,
                   output ready);
endinterface

// ----- rtl/gpt_core.sv -----
// Timer register file and counter logic; computes one response per accepted request.
module gpt_core import gpt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   input  gpt_req_type req_item,
   output gpt_rsp_type rsp_item
);

   logic [DATA_W-1:0] cr1_ff, cr1_in;
   logic [DATA_W-1:0] dier_ff, dier_in;
   logic [DATA_W-1:0] sr_ff, sr_in;
   logic [DATA_W-1:0] psc_ff, psc_in;
   logic [DATA_W-1:0] arr_ff, arr_in;
   logic [DATA_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0] pcnt_ff, pcnt_in;

   logic running;
   logic counting;

   assign running  = cr1_ff[0];
   assign counting = running && (arr_ff != '0);

   always_comb begin
      cr1_in   = cr1_ff;
      dier_in  = dier_ff;
      sr_in    = sr_ff;
      psc_in   = psc_ff;
      arr_in   = arr_ff;
      cnt_in   = cnt_ff;
      pcnt_in  = pcnt_ff;
      rsp_item = '0;

      case (req_item.kind)
         KIND_TICK: begin
            if (counting) begin
               if (pcnt_ff < psc_ff) begin
                  pcnt_in = pcnt_ff + 1'b1;
               end else begin
                  pcnt_in = '0;
                  // a loaded count at or above reload also wraps here
                  if (cnt_ff >= arr_ff - 1'b1) begin
                     cnt_in             = '0;
                     sr_in[0]           = 1'b1;
                     rsp_item.irq_pulse = dier_ff[0];
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
            end
         end
         KIND_READ: begin
            unique case (req_item.reg_offset)
               OFF_CR1:  rsp_item.read_data = cr1_ff;
               OFF_DIER: rsp_item.read_data = dier_ff;
               OFF_SR:   rsp_item.read_data = sr_ff;
               OFF_CNT:  rsp_item.read_data = counting ? cnt_ff : '0;
               OFF_PSC:  rsp_item.read_data = psc_ff;
               OFF_ARR:  rsp_item.read_data = arr_ff;
               default:  rsp_item.read_data = '0;
            endcase
         end
         KIND_WRITE: begin
            unique case (req_item.reg_offset)
               OFF_CR1: begin
                  cr1_in = req_item.write_data;
                  // restart on enable rising
                  if (!running && req_item.write_data[0]) begin
                     cnt_in  = '0;
                     pcnt_in = '0;
                  end
               end
               OFF_DIER: dier_in = req_item.write_data;
               OFF_SR:   sr_in   = sr_ff & req_item.write_data;
               OFF_CNT: begin
                  cnt_in  = req_item.write_data;
                  pcnt_in = '0;
               end
               OFF_PSC: begin
                  psc_in = req_item.write_data;
                  if (running) begin
                     cnt_in  = '0;
                     pcnt_in = '0;
                  end
               end
               OFF_ARR: begin
                  arr_in = req_item.write_data;
                  if (running) begin
                     cnt_in  = '0;
                     pcnt_in = '0;
                  end
               end
               default: rsp_item.write_error = 1'b1;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cr1_ff  <= '0;
         dier_ff <= '0;
         sr_ff   <= '0;
         psc_ff  <= '0;
         arr_ff  <= ARR_RESET;
         cnt_ff  <= '0;
         pcnt_ff <= '0;
      end else if (req_fire) begin
         cr1_ff  <= cr1_in;
         dier_ff <= dier_in;
         sr_ff   <= sr_in;
         psc_ff  <= psc_in;
         arr_ff  <= arr_in;
         cnt_ff  <= cnt_in;
         pcnt_ff <= pcnt_in;
      end
   end

endmodule

// ----- rtl/general_purpose_timer_regs_top.sv -----
// Top level of the general purpose timer: request channel, response register.
//
//   channel  dir  payload                               role
//   req      in   kind, reg_offset, write_data          tick, read or write
//   rsp      out  read_data, write_error, irq_pulse     one response per request
//
// One request is taken per cycle while req_ready is high; its response shows in the
// next cycle from the response register, which the core's single-pass logic fills.
// Reset (synchronous) clears all timer registers but reload, which comes up as all ones.
// req_ready stays high while the response register is empty or being drained,
// so a stalled rsp holds its data and stops new transfers only when full.
module general_purpose_timer_regs_top import gpt_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   gpt_req_if.sink   req,
   gpt_rsp_if.source rsp
);

   gpt_req_type req_item;
   gpt_rsp_type core_rsp;
   gpt_rsp_type rsp_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        req_fire;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;

   assign req_item.kind       = req.kind;
   assign req_item.reg_offset = req.reg_offset;
   assign req_item.write_data = req.write_data;

   gpt_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_item (req_item),
      .rsp_item (core_rsp)
   );

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.read_data   = rsp_data_ff.read_data;
   assign rsp.write_error = rsp_data_ff.write_error;
   assign rsp.irq_pulse   = rsp_data_ff.irq_pulse;

endmodule

// ----- test/general_purpose_timer_regs_top_test.sv -----
// Self-checking testbench for the general purpose timer register block.
module general_purpose_timer_regs_top_test;
   import gpt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [DATA_W-1:0] CR1_EN      = 32'h1;
   localparam logic [DATA_W-1:0] DIER_UIE    = 32'h1;
   localparam logic [DATA_W-1:0] SR_UIF      = 32'h1;
   localparam logic [DATA_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic [OFFSET_W-1:0] OFF_BAD_HI = 8'hFF;
   localparam int unsigned RANDOM_ITEMS = 1000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned TIMEOUT_NS   = 1_000_000;

   typedef enum int unsigned {
      RDY_ALWAYS,
      RDY_RANDOM,
      RDY_LONG_STALL,
      RDY_ALTERNATE
   } rdy_mode_type;

   logic clock;
   logic reset;

   gpt_req_if req_ch ();
   gpt_rsp_if rsp_ch ();

   general_purpose_timer_regs_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // timer state as the block should hold it
   logic [DATA_W-1:0] tm_ctrl;
   logic [DATA_W-1:0] tm_ier;
   logic [DATA_W-1:0] tm_status;
   logic [DATA_W-1:0] tm_psc;
   logic [DATA_W-1:0] tm_arr;
   logic [DATA_W-1:0] tm_cnt;
   logic [DATA_W-1:0] tm_prescale;

   gpt_rsp_type pending_responses[$];
   gpt_rsp_type exp_rsp;
   int unsigned error_count = 0;
   int unsigned items_sent  = 0;
   int unsigned burst_left  = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("[general_purpose_timer_regs_top] ERROR");
      $finish;
   end

   function automatic logic timer_running();
      return (tm_ctrl & CR1_EN) != 0;
   endfunction

   function automatic gpt_rsp_type predict_timer_response(input logic [KIND_W-1:0] kind,
         input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] data);
      gpt_rsp_type r;
      logic was_on;
      r = '0;
      was_on = timer_running();
      case (kind)
         KIND_TICK: begin
            if (timer_running() && tm_arr != 0) begin
               if (tm_prescale < tm_psc) begin
                  tm_prescale = tm_prescale + 1'b1;
               end else begin
                  tm_prescale = '0;
                  if (tm_cnt >= tm_arr - 32'd1) begin
                     tm_cnt = '0;
                     tm_status = tm_status | SR_UIF;
                     r.irq_pulse = (tm_ier & DIER_UIE) != 0;
                  end else begin
                     tm_cnt = tm_cnt + 1'b1;
                  end
               end
            end
         end
         KIND_READ: begin
            case (off)
               OFF_CR1:  r.read_data = tm_ctrl;
               OFF_DIER: r.read_data = tm_ier;
               OFF_SR:   r.read_data = tm_status;
               OFF_CNT:  r.read_data = (timer_running() && tm_arr != 0) ? tm_cnt : '0;
               OFF_PSC:  r.read_data = tm_psc;
               OFF_ARR:  r.read_data = tm_arr;
               default:  r.read_data = '0;
            endcase
         end
         KIND_WRITE: begin
            case (off)
               OFF_CR1: begin
                  tm_ctrl = data;
                  if (!was_on && timer_running()) begin
                     tm_cnt = '0;
                     tm_prescale = '0;
                  end
               end
               OFF_DIER: tm_ier = data;
               OFF_SR:   tm_status = tm_status & data;
               OFF_CNT: begin
                  tm_cnt = data;
                  tm_prescale = '0;
               end
               OFF_PSC, OFF_ARR: begin
                  if (off == OFF_PSC) tm_psc = data;
                  else tm_arr = data;
                  if (was_on) begin
                     tm_cnt = '0;
                     tm_prescale = '0;
                  end
               end
               default: r.write_error = 1'b1;
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [DATA_W-1:0] expd,
         input logic [DATA_W-1:0] act);
      if (act !== expd) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, expd, act);
         error_count++;
      end
   endfunction

   function automatic logic [OFFSET_W-1:0] pick_known_offset();
      case ($urandom_range(0, 5))
         0: return OFF_CR1;
         1: return OFF_DIER;
         2: return OFF_SR;
         3: return OFF_CNT;
         4: return OFF_PSC;
         default: return OFF_ARR;
      endcase
   endfunction

   // request capture comes first so a same-edge response still finds its entry
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            pending_responses.push_back(predict_timer_response(req_ch.kind,
                  req_ch.reg_offset, req_ch.write_data));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_responses.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual %h/%b/%b", $time,
                     rsp_ch.read_data, rsp_ch.write_error, rsp_ch.irq_pulse);
               error_count++;
            end else begin
               exp_rsp = pending_responses.pop_front();
               check_field("read_data", exp_rsp.read_data, rsp_ch.read_data);
               check_field("write_error", DATA_W'(exp_rsp.write_error),
                     DATA_W'(rsp_ch.write_error));
               check_field("irq_pulse", DATA_W'(exp_rsp.irq_pulse),
                     DATA_W'(rsp_ch.irq_pulse));
            end
         end
      end
   end

   // receiver backpressure, switching among four ready patterns
   initial begin : rsp_stall_pattern
      rdy_mode_type mode;
      int unsigned phase_left;
      int unsigned hold;
      mode = RDY_ALWAYS;
      phase_left = 0;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (phase_left == 0) begin
            mode = rdy_mode_type'($urandom_range(0, 3));
            phase_left = $urandom_range(16, 96);
         end
         phase_left--;
         case (mode)
            RDY_ALWAYS: rsp_ch.ready <= 1'b1;
            RDY_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            RDY_LONG_STALL: begin
               if (hold == 0) begin
                  hold = $urandom_range(1, 8);
                  rsp_ch.ready <= ~rsp_ch.ready;
               end
               hold--;
            end
            default: rsp_ch.ready <= phase_left[0];
         endcase
      end
   end

   // called at a falling edge; returns at a falling edge after the transfer
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [OFFSET_W-1:0] off,
         input logic [DATA_W-1:0] data);
      int unsigned gap;
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.reg_offset <= off;
      req_ch.write_data <= data;
      do @(posedge clock); while (!req_ch.ready);
      if (kind != KIND_UNUSED) items_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic test_reset_values();
      send_item(KIND_READ, OFF_CR1, '0);
      send_item(KIND_READ, OFF_DIER, '0);
      send_item(KIND_READ, OFF_SR, '0);
      send_item(KIND_READ, OFF_CNT, '0);
      send_item(KIND_READ, OFF_PSC, '0);
      send_item(KIND_READ, OFF_ARR, '0);
      send_item(KIND_READ, OFF_BAD_HI, ALL_ONES);
      send_item(KIND_UNUSED, OFF_BAD_HI, ALL_ONES);
      send_item(KIND_TICK, OFF_CR1, ALL_ONES);
   endtask

   task automatic test_register_access();
      send_item(KIND_WRITE, OFF_BAD_HI, ALL_ONES);
      send_item(KIND_WRITE, OFF_DIER, ALL_ONES);
      send_item(KIND_READ, OFF_DIER, '0);
      // ones into the status register must not set anything
      send_item(KIND_WRITE, OFF_SR, ALL_ONES);
      send_item(KIND_WRITE, OFF_PSC, ALL_ONES);
      send_item(KIND_READ, OFF_PSC, '0);
      send_item(KIND_WRITE, OFF_PSC, '0);
   endtask

   task automatic test_update_event();
      send_item(KIND_WRITE, OFF_ARR, 32'd2);
      send_item(KIND_WRITE, OFF_CR1, CR1_EN);
      repeat (4) send_item(KIND_TICK, '0, '0);
      send_item(KIND_READ, OFF_SR, '0);
      send_item(KIND_WRITE, OFF_SR, '0);
      send_item(KIND_READ, OFF_CNT, '0);
   endtask

   task automatic test_special_cases();
      // count loaded above reload wraps on its next advance
      send_item(KIND_WRITE, OFF_CNT, ALL_ONES);
      send_item(KIND_TICK, '0, '0);
      send_item(KIND_READ, OFF_CNT, '0);
      send_item(KIND_WRITE, OFF_ARR, '0);
      send_item(KIND_TICK, '0, '0);
      send_item(KIND_READ, OFF_CNT, '0);
      send_item(KIND_WRITE, OFF_CR1, '0);
   endtask

   task automatic test_random_traffic();
      int unsigned start;
      int unsigned n;
      int unsigned pick;
      logic [DATA_W-1:0] psc_val;
      logic [DATA_W-1:0] arr_val;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            // noise: any kind, any offset, any data
            repeat ($urandom_range(1, 8))
               send_item(KIND_W'($urandom_range(0, 3)), OFFSET_W'($urandom_range(0, 255)),
                     $urandom);
         end else begin
            // program the timer, start it, then mostly ticks
            psc_val = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
            case ($urandom_range(0, 9))
               0: arr_val = '0;
               1: arr_val = ALL_ONES;
               2: arr_val = $urandom;
               default: arr_val = $urandom_range(1, 6);
            endcase
            if ($urandom_range(0, 1))
               send_item(KIND_WRITE, OFF_CR1, $urandom & ~CR1_EN);
            send_item(KIND_WRITE, OFF_PSC, psc_val);
            send_item(KIND_WRITE, OFF_ARR, arr_val);
            send_item(KIND_WRITE, OFF_DIER, $urandom);
            send_item(KIND_WRITE, OFF_CR1, $urandom | CR1_EN);
            if ($urandom_range(0, 9) < 3)
               send_item(KIND_WRITE, OFF_CNT, $urandom_range(0, 1) ? $urandom_range(0, 8)
                                                                  : ALL_ONES - $urandom_range(0, 2));
            n = $urandom_range(8, 40);
            repeat (n) begin
               pick = $urandom_range(0, 99);
               if (pick < 78)
                  send_item(KIND_TICK, OFFSET_W'($urandom_range(0, 255)), $urandom);
               else if (pick < 88)
                  send_item(KIND_READ, pick_known_offset(), $urandom);
               else if (pick < 93)
                  send_item(KIND_WRITE, OFF_SR, $urandom);
               else if (pick < 97)
                  send_item(KIND_WRITE, OFF_CNT, $urandom_range(0, 1) ? $urandom_range(0, 8)
                                                                    : $urandom);
               else
                  send_item(KIND_WRITE, pick_known_offset(), $urandom_range(0, 7));
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_TICK;
      req_ch.reg_offset = '0;
      req_ch.write_data = '0;
      tm_ctrl = '0;
      tm_ier = '0;
      tm_status = '0;
      tm_psc = '0;
      tm_arr = ARR_RESET;
      tm_cnt = '0;
      tm_prescale = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_register_access();
      test_update_event();
      test_special_cases();
      test_random_traffic();

      req_ch.valid <= 1'b0;
      while (pending_responses.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("[general_purpose_timer_regs_top] OK");
      else
         $display("[general_purpose_timer_regs_top] ERROR");
      $finish;
   end

endmodule
